// ===== design/pcbp_pkg.sv =====
// Shared types, constants and code tables of the prefix code bit packer.
package pcbp_pkg;

  // Field widths.
  localparam int CodeW  = 16;
  localparam int LenW   = 5;
  localparam int ModeW  = 3;
  localparam int SymW   = 8;
  localparam int ByteW  = 8;
  localparam int TotalW = 32;

  // Residual bits plus one longest code word.
  localparam int BufW  = CodeW + ByteW;
  localparam int FillW = 5;

  // Depth of the queue between classifier and packer.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Opcodes of an input transaction.
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_ENCODE = 2'd0;
  localparam opcode_t OP_RAW    = 2'd1;
  localparam opcode_t OP_END    = 2'd2;

  // Code modes.
  typedef logic [ModeW-1:0] mode_t;
  localparam mode_t MODE_BYTE_6_16    = 3'd0;
  localparam mode_t MODE_BYTE_4_8_16  = 3'd1;
  localparam mode_t MODE_NIB_UNARY    = 3'd2;
  localparam mode_t MODE_NIB_3_TO_11  = 3'd3;
  localparam mode_t MODE_NIB_3_5_8    = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_CODE_MODE  = 1'b0;
  localparam logic CFG_END_MARKER = 1'b1;

  // Result kinds.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // One classified work item: a right-aligned code word and its length.
  typedef struct packed {
    logic             is_end;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } code_item_t;

  // Nibble code with lengths 1, 3, 5, 7, 9 and 11.
  function automatic logic [CodeW-1:0] nib35_code(input logic [3:0] nib);
    logic [CodeW-1:0] c;
    case (nib)
      4'd0:    c = 16'h000;
      4'd1:    c = 16'h004;
      4'd2:    c = 16'h005;
      4'd3:    c = 16'h006;
      4'd4:    c = 16'h01C;
      4'd5:    c = 16'h01D;
      4'd6:    c = 16'h01E;
      4'd7:    c = 16'h07C;
      4'd8:    c = 16'h07D;
      4'd9:    c = 16'h07E;
      4'd10:   c = 16'h1FC;
      4'd11:   c = 16'h1FD;
      4'd12:   c = 16'h1FE;
      4'd13:   c = 16'h7FC;
      4'd14:   c = 16'h7FD;
      default: c = 16'h7FE;
    endcase
    return c;
  endfunction

  function automatic logic [LenW-1:0] nib35_len(input logic [3:0] nib);
    logic [LenW-1:0] l;
    case (nib)
      4'd0:                  l = 5'd1;
      4'd1, 4'd2, 4'd3:      l = 5'd3;
      4'd4, 4'd5, 4'd6:      l = 5'd5;
      4'd7, 4'd8, 4'd9:      l = 5'd7;
      4'd10, 4'd11, 4'd12:   l = 5'd9;
      default:               l = 5'd11;
    endcase
    return l;
  endfunction

  // Nibble code with lengths 3, 5 and 8.
  function automatic logic [CodeW-1:0] nib358_code(input logic [3:0] nib);
    logic [CodeW-1:0] c;
    case (nib)
      4'd7:    c = 16'h1C;
      4'd8:    c = 16'h1D;
      4'd9:    c = 16'h1E;
      4'd10:   c = 16'hF8;
      4'd11:   c = 16'hF9;
      4'd12:   c = 16'hFA;
      4'd13:   c = 16'hFB;
      4'd14:   c = 16'hFC;
      4'd15:   c = 16'hFD;
      default: c = {12'h000, nib};
    endcase
    return c;
  endfunction

  function automatic logic [LenW-1:0] nib358_len(input logic [3:0] nib);
    logic [LenW-1:0] l;
    if (nib < 4'd7) begin
      l = 5'd3;
    end else if (nib < 4'd10) begin
      l = 5'd5;
    end else begin
      l = 5'd8;
    end
    return l;
  endfunction

endpackage

// ===== design/prefix_code_bit_packer.sv =====
// Top level of the prefix code bit packer.
//
// Each input transaction is turned into a code word of up to 16 bits (by the
// selected code mode, as raw bits, or as the end marker), and the bits are
// packed MSB first into bytes that leave on the master stream, one result
// per cycle while m_axis_tready allows. A front end classifies transactions
// and feeds a two-entry queue; the back end merges one code word into its
// bit buffer whenever fewer than eight bits remain, so the packer's single
// output byte per cycle sets the rate. An end transaction gives two or three
// bytes, then the byte count, which carries tlast and tuser high, and the next
// code word is only merged in the cycle after the count. tlast marks the last
// result of each input transaction. Configuration must be written through
// cfg_we only while idle; the block itself does not enforce this.
module prefix_code_bit_packer import pcbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // symbol[7:0], raw_bits[23:8], raw_length[28:24]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // packed_byte[7:0], byte_total[39:8]
  output logic        m_axis_tuser,  // result_kind[0]
  output logic        m_axis_tlast
);

  mode_t            code_mode;
  logic [CodeW-1:0] end_marker;
  logic             q_full;
  logic             q_not_empty;
  logic             push;
  logic             pop;
  code_item_t       push_item;
  code_item_t       q_item;
  logic [ByteW-1:0] out_byte;
  logic [TotalW-1:0] out_total;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_mode  <= MODE_BYTE_6_16;
      end_marker <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_MODE:  code_mode  <= cfg_data[ModeW-1:0];
        CFG_END_MARKER: end_marker <= cfg_data;
        default: ;
      endcase
    end
  end

  pcbp_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .opcode     (s_axis_tuser),
    .symbol     (s_axis_tdata[7:0]),
    .raw_bits   (s_axis_tdata[23:8]),
    .raw_length (s_axis_tdata[28:24]),
    .code_mode  (code_mode),
    .end_marker (end_marker),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  pcbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_item   (q_item)
  );

  pcbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_byte  (out_byte),
    .out_total (out_total),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_total, out_byte};

endmodule

// ===== design/pcbp_front.sv =====
// Front end: accepts input transactions and turns each into a code word and length.
module pcbp_front import pcbp_pkg::*; (
  input  logic              in_valid,
  output logic              in_ready,
  input  opcode_t           opcode,
  input  logic [SymW-1:0]   symbol,
  input  logic [CodeW-1:0]  raw_bits,
  input  logic [LenW-1:0]   raw_length,
  input  mode_t             code_mode,
  input  logic [CodeW-1:0]  end_marker,
  input  logic              q_full,
  output logic              push,
  output code_item_t        push_item
);

  logic [3:0]      nib;
  logic [CodeW-1:0] sym16;
  code_item_t      item;

  assign nib   = symbol[3:0];
  assign sym16 = {8'h00, symbol};

  // Code selection for each opcode and mode.
  always_comb begin
    item = '0;
    case (opcode)
      OP_ENCODE: begin
        unique case (code_mode)
          MODE_BYTE_6_16: begin
            if (symbol < 8'h3F) begin
              item.code = sym16;
              item.len  = 5'd6;
            end else begin
              item.code = 16'hFC00 | {8'h00, symbol - 8'h3F};
              item.len  = 5'd16;
            end
          end
          MODE_BYTE_4_8_16: begin
            if (symbol < 8'h0F) begin
              item.code = sym16;
              item.len  = 5'd4;
            end else if (symbol < 8'h1E) begin
              item.code = {8'h00, symbol + 8'hE1};
              item.len  = 5'd8;
            end else begin
              item.code = sym16 + 16'hFEE2;
              item.len  = 5'd16;
            end
          end
          MODE_NIB_UNARY: begin
            item.code = 16'((17'd1 << ({1'b0, nib} + 5'd1)) - 17'd2);
            item.len  = {1'b0, nib} + 5'd1;
          end
          MODE_NIB_3_TO_11: begin
            item.code = nib35_code(nib);
            item.len  = nib35_len(nib);
          end
          MODE_NIB_3_5_8: begin
            item.code = nib358_code(nib);
            item.len  = nib358_len(nib);
          end
          default: begin
            // Unknown modes write nothing.
            item = '0;
          end
        endcase
      end
      OP_RAW: begin
        item.code = raw_bits;
        item.len  = (raw_length > 5'd16) ? 5'd16 : raw_length;
      end
      OP_END: begin
        item.is_end = 1'b1;
        item.code   = end_marker;
        item.len    = 5'd16;
      end
      default: begin
        item = '0;
      end
    endcase
  end

  // Items that write nothing are accepted and dropped here.
  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full && (item.is_end || (item.len != '0));
  assign push_item = item;

endmodule

// ===== design/pcbp_queue.sv =====
// Short queue of classified code items between front end and packer.
module pcbp_queue import pcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  code_item_t wr_item,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output code_item_t rd_item
);

  code_item_t             entries [QueueDepth];
  logic [QPtrW-1:0]       wr_ptr;
  logic [QPtrW-1:0]       rd_ptr;
  logic [QCntW-1:0]       cnt;

  assign full      = (cnt == QCntW'(QueueDepth));
  assign not_empty = (cnt != '0);
  assign rd_item   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== design/pcbp_back.sv =====
// Back end: packs code words MSB first and emits bytes and the final count.
module pcbp_back import pcbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  code_item_t        q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [ByteW-1:0]  out_byte,
  output logic [TotalW-1:0] out_total,
  output logic              out_last
);

  // Bit buffer: valid bits sit at the top, everything below them is zero.
  logic [BufW-1:0]   bits;
  logic [FillW-1:0]  fill;
  logic              end_pend;
  logic [TotalW-1:0] byte_cnt;

  logic              out_free;
  logic              emit_byte;
  logic              emit_pad;
  logic              emit_cnt;
  logic [BufW-1:0]   bits_shift;
  logic [FillW-1:0]  fill_shift;
  logic              can_load;
  logic [CodeW-1:0]  code_left;
  logic [BufW-1:0]   code_place;
  logic [BufW-1:0]   bits_next;
  logic [FillW-1:0]  fill_next;

  assign out_free  = !out_valid || out_ready;
  assign emit_byte = out_free && (fill >= FillW'(ByteW));
  assign emit_pad  = out_free && (fill < FillW'(ByteW)) && end_pend && (fill != '0);
  assign emit_cnt  = out_free && end_pend && (fill == '0);

  // Drop the top byte when it goes out.
  assign bits_shift = emit_byte ? (bits << ByteW) : bits;
  assign fill_shift = emit_byte ? (fill - FillW'(ByteW)) : fill;

  // A new code is merged once fewer than eight bits remain.
  assign can_load   = !end_pend && (fill_shift < FillW'(ByteW));
  assign pop        = q_valid && can_load;
  assign code_left  = q_item.code << (5'd16 - q_item.len);
  assign code_place = {code_left, {ByteW{1'b0}}} >> fill_shift[2:0];

  always_comb begin
    bits_next = bits_shift;
    fill_next = fill_shift;
    if (pop) begin
      bits_next = bits_shift | code_place;
      fill_next = fill_shift + q_item.len;
    end else if (emit_pad || emit_cnt) begin
      bits_next = '0;
      fill_next = '0;
    end
  end

  // Packer state and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits     <= '0;
      fill     <= '0;
      end_pend <= 1'b0;
      byte_cnt <= '0;
    end else begin
      bits <= bits_next;
      fill <= fill_next;
      if (pop) begin
        end_pend <= q_item.is_end;
      end else if (emit_cnt) begin
        end_pend <= 1'b0;
      end
      if (emit_cnt) begin
        byte_cnt <= '0;
      end else if ((emit_byte || emit_pad) && (byte_cnt != '1)) begin
        byte_cnt <= byte_cnt + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit_byte || emit_pad || emit_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_byte || emit_pad) begin
      out_kind  <= KIND_BYTE;
      out_byte  <= bits[BufW-1 -: ByteW];
      out_total <= '0;
      out_last  <= emit_byte && !end_pend && (fill_shift < FillW'(ByteW));
    end else if (emit_cnt) begin
      out_kind  <= KIND_COUNT;
      out_byte  <= '0;
      out_total <= byte_cnt;
      out_last  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // The buffer never holds more than residual bits plus one code word.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FillW'(BufW - 1))
    else $error("bit buffer overfilled");

  // Nothing is merged while an end item is being flushed.
  a_no_load_on_end: assert property (@(posedge clk) disable iff (rst)
    end_pend |-> !pop)
    else $error("code merged during end flush");

  // A count result closes its run.
  a_count_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_COUNT)) |-> out_last)
    else $error("count result not marked last");

  // The stream restarts from an empty packer after the count.
  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    emit_cnt |=> ((byte_cnt == '0) && (fill == '0) && !end_pend))
    else $error("packer not cleared after count");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the prefix code bit packer stream block.
`timescale 1ns / 100ps

module tb;
  import pcbp_pkg::*;

  // Opcode 3 has no function and must be swallowed without a result.
  localparam opcode_t OP_NONE = 2'd3;
  // Mode values past the defined codes write nothing.
  localparam mode_t MODE_SPARE_LO = 3'd5;
  localparam mode_t MODE_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_GOAL   = 470;

  // One result of the block, as the packing predictor expects it.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] total;
    logic        last;
  } pack_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_CODE_MODE;
  logic [15:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // symbol[7:0], raw_bits[23:8], raw_length[28:24]
  logic [1:0] s_axis_tuser = OP_ENCODE;  // opcode[1:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // packed_byte[7:0], byte_total[39:8]
  logic m_axis_tuser;  // result_kind[0]
  logic m_axis_tlast;

  // Predictor copy of the registers and of the packing state.
  mode_t       cur_mode = MODE_BYTE_6_16;
  logic [15:0] cur_marker = 16'hFFFF;
  logic [7:0]  pk_acc = '0;
  int          pk_fill = 0;
  logic [31:0] pk_count = '0;

  pack_result_t owed_results[$];
  int errors = 0;
  int n_items = 0;
  int n_ends = 0;
  int n_results = 0;
  int n_settings = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;

  prefix_code_bit_packer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Code word and length that a mode assigns to a symbol; length 0 means no bits.
  function automatic code_item_t code_for_symbol(input mode_t m, input logic [7:0] s);
    code_item_t ci;
    logic [3:0] n;
    logic [31:0] t;
    int g;
    ci = '0;
    n = s[3:0];
    case (m)
      MODE_BYTE_6_16: begin
        if (s < 8'h3F) begin
          ci.code = {8'h00, s};
          ci.len = 5'd6;
        end else begin
          ci.code = 16'hFC00 | {8'h00, s - 8'h3F};
          ci.len = 5'd16;
        end
      end
      MODE_BYTE_4_8_16: begin
        if (s < 8'h0F) begin
          ci.code = {8'h00, s};
          ci.len = 5'd4;
        end else if (s < 8'h1E) begin
          ci.code = {8'h00, s} + 16'h00E1;
          ci.len = 5'd8;
        end else begin
          ci.code = {8'h00, s} + 16'hFEE2;
          ci.len = 5'd16;
        end
      end
      MODE_NIB_UNARY: begin
        // n ones followed by a zero.
        g = n + 1;
        t = (32'd1 << g) - 32'd2;
        ci.code = t[15:0];
        ci.len = 5'(g);
      end
      MODE_NIB_3_TO_11: begin
        // A run of 2g+1 ones, then a 2-bit index within the group of three.
        if (n == 4'd0) begin
          ci.len = 5'd1;
        end else begin
          g = (n - 1) / 3;
          t = (((32'd1 << (2 * g + 1)) - 32'd1) << 2) | ((n - 1) % 3);
          ci.code = t[15:0];
          ci.len = 5'(2 * g + 3);
        end
      end
      MODE_NIB_3_5_8: begin
        if (n < 4'd7) begin
          ci.code = {12'h000, n};
          ci.len = 5'd3;
        end else if (n < 4'd10) begin
          ci.code = 16'h001C + (n - 4'd7);
          ci.len = 5'd5;
        end else begin
          ci.code = 16'h00F8 + (n - 4'd10);
          ci.len = 5'd8;
        end
      end
      default: ci.len = '0;
    endcase
    return ci;
  endfunction

  // A full (or flushed) accumulator byte leaves as a byte result.
  task automatic emit_byte();
    pack_result_t r;
    r = '{kind: KIND_BYTE, data_byte: pk_acc, total: 32'd0, last: 1'b0};
    owed_results.push_back(r);
    pk_acc = '0;
    pk_fill = 0;
    if (pk_count != 32'hFFFF_FFFF) pk_count++;
  endtask

  // Packs a right-aligned code word MSB first into the accumulator.
  task automatic shift_in_bits(input logic [15:0] code, input int len);
    for (int i = len; i > 0; i--) begin
      pk_acc[7 - pk_fill] = code[i - 1];
      pk_fill++;
      if (pk_fill == 8) emit_byte();
    end
  endtask

  // Works out the results of one accepted transaction and queues them.
  task automatic predict_packing(input opcode_t op, input logic [7:0] sym,
                                 input logic [15:0] raw, input logic [4:0] rlen);
    code_item_t ci;
    pack_result_t r;
    int before_n;
    before_n = owed_results.size();
    case (op)
      OP_ENCODE: begin
        ci = code_for_symbol(cur_mode, sym);
        shift_in_bits(ci.code, ci.len);
      end
      OP_RAW: shift_in_bits(raw, (rlen > 5'd16) ? 16 : rlen);
      OP_END: begin
        shift_in_bits(cur_marker, 16);
        if (pk_fill != 0) emit_byte();
        r = '{kind: KIND_COUNT, data_byte: 8'h00, total: pk_count, last: 1'b0};
        owed_results.push_back(r);
        pk_acc = '0;
        pk_fill = 0;
        pk_count = '0;
      end
      default: ;
    endcase
    // The final result of this transaction carries tlast.
    if (owed_results.size() > before_n) begin
      r = owed_results.pop_back();
      r.last = 1'b1;
      owed_results.push_back(r);
    end
  endtask

  // Offers one transaction, with bursts and gaps, and waits for its handshake.
  task automatic send_item(input opcode_t op, input logic [7:0] sym,
                           input logic [15:0] raw, input logic [4:0] rlen);
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, rlen, raw, sym};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_packing(op, sym, raw, rlen);
    if (op != OP_NONE) n_items++;
    if (op == OP_END) n_ends++;
  endtask

  task automatic send_symbol(input logic [7:0] sym);
    send_item(OP_ENCODE, sym, 16'($urandom), 5'($urandom));
  endtask

  task automatic send_raw(input logic [15:0] raw, input logic [4:0] rlen);
    send_item(OP_RAW, 8'($urandom), raw, rlen);
  endtask

  task automatic send_end();
    send_item(OP_END, 8'($urandom), 16'($urandom), 5'($urandom));
  endtask

  // Stops offering and waits until the block has delivered all results and gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CODE_MODE) cur_mode = val[ModeW-1:0];
    else cur_marker = val;
    n_settings++;
  endtask

  task automatic log_failure(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    pack_result_t want;
    pack_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, data_byte: m_axis_tdata[7:0],
              total: m_axis_tdata[39:8], last: m_axis_tlast};
      n_results++;
      if (owed_results.size() == 0) begin
        log_failure($sformatf("unexpected result kind=%0d byte=%02h total=%0d last=%0d",
                              got.kind, got.data_byte, got.total, got.last));
      end else begin
        want = owed_results.pop_front();
        if (got.kind != want.kind || got.data_byte != want.data_byte ||
            got.total != want.total || got.last != want.last) begin
          log_failure($sformatf(
              "expected kind=%0d byte=%02h total=%0d last=%0d, got kind=%0d byte=%02h total=%0d last=%0d",
              want.kind, want.data_byte, want.total, want.last,
              got.kind, got.data_byte, got.total, got.last));
        end
      end
    end
  end

  // Receiver: stall styles that change now and then, plus a long hold-off on request.
  initial begin : result_sink
    int style;
    int rx_cyc;
    style = 0;
    rx_cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        rx_cyc++;
        if (rx_cyc % 50 == 0) style = $urandom_range(0, 3);
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((rx_cyc % 7) < 4);
        endcase
      end
    end
  end

  // Watchdog: too many cycles in a row without any transaction ends the run.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] Timeout with %0d results still owed.", $time, owed_results.size());
    $display("Some tests failed");
    $finish;
  end

  // Byte codes: mode 0 from its reset value, then mode 1, around each threshold.
  task automatic test_byte_codes();
    send_symbol(8'h00);
    send_symbol(8'h3E);
    send_symbol(8'h3F);
    send_symbol(8'hFF);
    send_end();
    settle();
    write_reg(CFG_CODE_MODE, 16'(MODE_BYTE_4_8_16));
    send_symbol(8'h0E);
    send_symbol(8'h0F);
    send_symbol(8'h1D);
    send_symbol(8'h1E);
    send_symbol(8'hFF);
  endtask

  // Nibble codes: shortest and longest words of each nibble mode.
  task automatic test_nibble_codes();
    settle();
    write_reg(CFG_CODE_MODE, 16'(MODE_NIB_UNARY));
    send_symbol(8'h0F);
    send_symbol(8'hF0);
    settle();
    write_reg(CFG_CODE_MODE, 16'(MODE_NIB_3_TO_11));
    send_symbol(8'h00);
    send_symbol(8'h0A);
    send_symbol(8'hFF);
    settle();
    write_reg(CFG_CODE_MODE, 16'(MODE_NIB_3_5_8));
    send_symbol(8'h06);
    send_symbol(8'h07);
    send_symbol(8'h0A);
    send_end();
  endtask

  // Raw writes, length clamping, ignored opcode, unknown modes and an empty end.
  task automatic test_raw_and_odd_items();
    settle();
    write_reg(CFG_END_MARKER, 16'h0000);
    send_raw(16'hFFFF, 5'd0);
    send_raw(16'hFFFF, 5'd16);
    send_raw(16'hA5A5, 5'd31);
    send_raw(16'hFFFA, 5'd3);
    send_item(OP_NONE, 8'hFF, 16'hFFFF, 5'h1F);
    settle();
    write_reg(CFG_CODE_MODE, 16'(MODE_SPARE_LO));
    send_symbol(8'hFF);
    settle();
    write_reg(CFG_CODE_MODE, 16'(MODE_SPARE_HI));
    send_symbol(8'h00);
    send_end();
    send_end();
  endtask

  // The receiver holds off for a long stretch while long codes keep coming in.
  task automatic test_output_stall();
    settle();
    write_reg(CFG_CODE_MODE, 16'(MODE_BYTE_6_16));
    write_reg(CFG_END_MARKER, 16'hFFFF);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (39) send_symbol(8'($urandom_range(8'h3F, 8'hFF)));
    send_end();
    gaps_on = 1'b1;
  endtask

  // Random streams under changing registers, with some noise and broken streams.
  task automatic test_random_streams();
    int phase;
    int sel;
    int len;
    mode_t m;
    logic [15:0] marker;
    phase = 0;
    while (n_items < ITEM_GOAL) begin
      settle();
      if (phase == 0) m = MODE_BYTE_6_16;
      else if (phase == 1) m = MODE_NIB_3_5_8;
      else if ($urandom_range(0, 9) == 0) m = mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else m = mode_t'($urandom_range(MODE_BYTE_6_16, MODE_NIB_3_5_8));
      if (phase % 4 == 0) marker = 16'h0000;
      else if (phase % 4 == 1) marker = 16'hFFFF;
      else marker = 16'($urandom);
      write_reg(CFG_CODE_MODE, 16'(m));
      write_reg(CFG_END_MARKER, marker);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(0, 25);
        repeat (len) begin
          sel = $urandom_range(0, 99);
          if (sel < 65) send_symbol(8'($urandom_range(0, 255)));
          else if (sel < 80) send_raw(16'($urandom), 5'($urandom_range(0, 16)));
          else if (sel < 85) send_raw(16'($urandom), 5'($urandom_range(17, 31)));
          else if (sel < 92) send_item(OP_NONE, 8'($urandom), 16'($urandom), 5'($urandom));
          else send_end();
        end
        // Now and then a stream is left open across a register change.
        if ($urandom_range(0, 7) != 0) send_end();
      end
      phase++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_byte_codes();
    test_nibble_codes();
    test_raw_and_odd_items();
    test_output_stall();
    test_random_streams();
    settle();
    $display("Run covered %0d transactions, %0d stream ends and %0d checked results",
             n_items, n_ends, n_results);
    $display("over %0d register writes in all code modes; %0d mismatches.",
             n_settings, errors);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== prefix_code_bit_packer.f =====
design/pcbp_pkg.sv
design/pcbp_front.sv
design/pcbp_queue.sv
design/pcbp_back.sv
design/prefix_code_bit_packer.sv
tb/tb.sv
